[sv/hid_keyboard_report_to_ascii_macros.svh]
// Assertion macros used by the keyboard report decoder top level.
`ifndef HID_KEYBOARD_REPORT_TO_ASCII_MACROS_SVH
`define HID_KEYBOARD_REPORT_TO_ASCII_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define HKRA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hkra assertion failed");

// Next-cycle implication, checked outside of reset.
`define HKRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hkra assertion failed");

`endif

[sv/hkra_pkg.sv]
// Package with constants, types and keymap tables of the keyboard report decoder.
`timescale 1ns / 1ps
`default_nettype none
package hkra_pkg;

   localparam int KEY_SLOTS      = 6;
   localparam int KEYMAP_ENTRIES = 104;
   localparam int CODE_W         = 8;
   localparam int CHAR_W         = 7;
   localparam int KEYMAP_IDX_W   = (KEYMAP_ENTRIES > 1) ? $clog2(KEYMAP_ENTRIES) : 1;
   localparam int HISTORY_W      = KEY_SLOTS * CODE_W;

   localparam logic [CODE_W-1:0] SHIFT_MASK = 8'h22;
   localparam logic [CODE_W-1:0] KEY_EMPTY  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] codes_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctrl_type;

   localparam char_type NORMAL_KEYMAP [KEYMAP_ENTRIES] = '{
      7'h00, 7'h00, 7'h00, 7'h00, 7'h61, 7'h62, 7'h63, 7'h64,
      7'h65, 7'h66, 7'h67, 7'h68, 7'h69, 7'h6a, 7'h6b, 7'h6c,
      7'h6d, 7'h6e, 7'h6f, 7'h70, 7'h71, 7'h72, 7'h73, 7'h74,
      7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a, 7'h31, 7'h32,
      7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
      7'h0a, 7'h00, 7'h08, 7'h09, 7'h20, 7'h2d, 7'h3d, 7'h5b,
      7'h5d, 7'h5c, 7'h23, 7'h3b, 7'h27, 7'h60, 7'h2c, 7'h2e,
      7'h2f, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h2f, 7'h2a, 7'h2d, 7'h2b,
      7'h0a, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h30, 7'h2e, 7'h5c, 7'h00, 7'h00, 7'h3d
   };

   localparam char_type SHIFTED_KEYMAP [KEYMAP_ENTRIES] = '{
      7'h00, 7'h00, 7'h00, 7'h00, 7'h41, 7'h42, 7'h43, 7'h44,
      7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4a, 7'h4b, 7'h4c,
      7'h4d, 7'h4e, 7'h4f, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
      7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5a, 7'h21, 7'h40,
      7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28, 7'h29,
      7'h0a, 7'h00, 7'h08, 7'h09, 7'h20, 7'h5f, 7'h2b, 7'h7b,
      7'h7d, 7'h7c, 7'h7e, 7'h3a, 7'h40, 7'h7e, 7'h3c, 7'h3e,
      7'h3f, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h2f, 7'h2a, 7'h2d, 7'h2b,
      7'h0a, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h30, 7'h2e, 7'h7c, 7'h00, 7'h00, 7'h3d
   };

endpackage
`default_nettype wire

[sv/hkra_channels.sv]
// Valid/ready channel interfaces for keyboard reports and decoded characters.
`timescale 1ns / 1ps
`default_nettype none
interface hkra_req_if;
   logic                      valid;
   logic                      ready;
   logic [hkra_pkg::CODE_W-1:0] slot0_code;
   logic [hkra_pkg::CODE_W-1:0] slot1_code;
   logic [hkra_pkg::CODE_W-1:0] slot2_code;
   logic [hkra_pkg::CODE_W-1:0] slot3_code;
   logic [hkra_pkg::CODE_W-1:0] slot4_code;
   logic [hkra_pkg::CODE_W-1:0] slot5_code;
   logic [hkra_pkg::CODE_W-1:0] modifier_bits;

   modport source (output valid, slot0_code, slot1_code, slot2_code, slot3_code,
                   slot4_code, slot5_code, modifier_bits, input ready);
   modport sink (input valid, slot0_code, slot1_code, slot2_code, slot3_code,
                 slot4_code, slot5_code, modifier_bits, output ready);
endinterface

interface hkra_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hkra_pkg::CHAR_W-1:0] key_char;

   modport source (output valid, key_char, input ready);
   modport sink (input valid, key_char, output ready);
endinterface
`default_nettype wire

[sv/hkra_history_mem.sv]
// One-row synchronous memory that holds the key codes of the previous report.
`timescale 1ns / 1ps
`default_nettype none
module hkra_history_mem (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire hkra_pkg::mem_ctrl_type   ctrl,
   input  wire hkra_pkg::codes_type      wr_data,
   output hkra_pkg::codes_type           rd_data
);

   hkra_pkg::codes_type mem [1];
   hkra_pkg::codes_type rd_data_ff;
   logic                written_ff;

   // Until the row is first written it reads as an all-empty report.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= 1'b0;
      end else if (ctrl.wr_en) begin
         written_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[0] <= wr_data;
      end
   end

   // Read-before-write: a read in the write cycle returns the old row.
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= written_ff ? mem[0] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/hkra_scan.sv]
// Slot scan: held-key check, keymap lookup and first-new-character selection.
`timescale 1ns / 1ps
`default_nettype none
module hkra_scan (
   input  wire hkra_pkg::codes_type codes,
   input  wire hkra_pkg::codes_type prev_codes,
   input  wire logic                shifted,
   output hkra_pkg::char_type       key_char
);

   hkra_pkg::char_type [hkra_pkg::KEY_SLOTS-1:0] cand;

   // Each slot yields its character, or none when held, out of table or unmapped.
   always_comb begin
      logic                                 held;
      logic [hkra_pkg::KEYMAP_IDX_W-1:0]    idx;
      logic                                 in_table;
      for (int s = 0; s < hkra_pkg::KEY_SLOTS; s++) begin
         held = 1'b0;
         for (int k = 0; k < hkra_pkg::KEY_SLOTS; k++) begin
            held = held | (prev_codes[k] == codes[s]);
         end
         in_table = ({1'b0, codes[s]} < (hkra_pkg::CODE_W + 1)'(hkra_pkg::KEYMAP_ENTRIES));
         idx      = hkra_pkg::KEYMAP_IDX_W'(codes[s]);
         if (!in_table || held) begin
            cand[s] = hkra_pkg::CHAR_NONE;
         end else if (shifted) begin
            cand[s] = hkra_pkg::SHIFTED_KEYMAP[idx];
         end else begin
            cand[s] = hkra_pkg::NORMAL_KEYMAP[idx];
         end
      end
   end

   // The scan ends at the first empty slot or the first character found.
   always_comb begin
      logic               done;
      hkra_pkg::char_type found;
      done  = 1'b0;
      found = hkra_pkg::CHAR_NONE;
      for (int s = 0; s < hkra_pkg::KEY_SLOTS; s++) begin
         if (!done) begin
            if (codes[s] == hkra_pkg::KEY_EMPTY) begin
               done = 1'b1;
            end else if (cand[s] != hkra_pkg::CHAR_NONE) begin
               found = cand[s];
               done  = 1'b1;
            end
         end
      end
      key_char = found;
   end

endmodule
`default_nettype wire

[sv/hid_keyboard_report_to_ascii.sv]
// Top level of the boot keyboard report to ASCII decoder.
`timescale 1ns / 1ps
`default_nettype none
`include "hid_keyboard_report_to_ascii_macros.svh"
// Takes one boot keyboard report per transaction and returns one transaction
// with the character of the first newly pressed key that has one, or 0 if none.
// A report is accepted every cycle while the result side keeps up; each
// result passes through stage register s1 and then the output register
// before it is presented. The previous report lives in a one-row history
// memory that is read and rewritten in the accept cycle, so its registered
// read output sets the length of the pipeline.
// Shift is taken from modifier bits 1 and 5; other modifier bits are ignored.
module hid_keyboard_report_to_ascii (
   input  wire logic  clock,
   input  wire logic  reset,
   hkra_req_if.sink   req_bus,
   hkra_rsp_if.source rsp_bus
);

   hkra_pkg::codes_type    req_codes;
   hkra_pkg::codes_type    prev_codes;
   hkra_pkg::mem_ctrl_type mem_ctrl;
   hkra_pkg::char_type     scan_char;

   logic                   req_accept;
   logic                   s1_adv;
   logic                   s1_valid_ff;
   hkra_pkg::codes_type    s1_codes_ff;
   logic                   s1_shift_ff;
   logic                   out_valid_ff;
   hkra_pkg::char_type     out_char_ff;

   assign req_codes[0] = req_bus.slot0_code;
   assign req_codes[1] = req_bus.slot1_code;
   assign req_codes[2] = req_bus.slot2_code;
   assign req_codes[3] = req_bus.slot3_code;
   assign req_codes[4] = req_bus.slot4_code;
   assign req_codes[5] = req_bus.slot5_code;

   assign s1_adv         = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !s1_valid_ff || s1_adv;
   assign req_accept     = req_bus.valid && req_bus.ready;
   assign mem_ctrl.rd_en = req_accept;
   assign mem_ctrl.wr_en = req_accept;

   hkra_history_mem u_history (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mem_ctrl),
      .wr_data (req_codes),
      .rd_data (prev_codes)
   );

   hkra_scan u_scan (
      .codes      (s1_codes_ff),
      .prev_codes (prev_codes),
      .shifted    (s1_shift_ff),
      .key_char   (scan_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_codes_ff <= req_codes;
         s1_shift_ff <= ((req_bus.modifier_bits & hkra_pkg::SHIFT_MASK) != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_char_ff <= scan_char;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.key_char = out_char_ff;

   `HKRA_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, s1_valid_ff)
   `HKRA_ASSERT_NEXT(a_stalled_stage_kept, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff)
   `HKRA_ASSERT_NOW(a_stall_blocks_input, clock, reset, s1_valid_ff && !s1_adv, !req_bus.ready)
   `HKRA_ASSERT_NEXT(a_drained_output_empties, clock, reset,
                     out_valid_ff && rsp_bus.ready && !s1_valid_ff, !out_valid_ff)

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the boot keyboard report to ASCII decoder.
`timescale 1ns / 1ps
module tb_top;

   localparam int CLOCK_PERIOD   = 20;
   localparam int TIMEOUT_CYCLES = 200_000;
   localparam int MAP_SIZE       = 104;
   localparam int SETTLE_CYCLES  = 10;
   localparam int REPORT_MAX     = 10;

   localparam hkra_pkg::code_type SHIFT_KEYS    = 8'h22;
   localparam hkra_pkg::code_type ROLLOVER_CODE = 8'h01;

   typedef struct packed {
      hkra_pkg::codes_type codes;
      hkra_pkg::code_type  mods;
   } key_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hkra_req_if req_bus ();
   hkra_rsp_if rsp_bus ();

   hid_keyboard_report_to_ascii dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hkra_pkg::char_type normal_chars [MAP_SIZE];
   hkra_pkg::char_type shifted_chars [MAP_SIZE];
   hkra_pkg::code_type held_codes [hkra_pkg::KEY_SLOTS];
   hkra_pkg::code_type pressed_keys [$];
   hkra_pkg::char_type expected_chars [$];

   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_off_cycles = 0;
   int failures        = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Keymaps of the decoder, rebuilt here from the printed key legends.
   initial begin : keymap_fill
      string digits_plain;
      string digits_shift;
      string punct_plain;
      string punct_shift;
      string keypad;
      digits_plain = "1234567890";
      digits_shift = "!@#$%^&*()";
      punct_plain  = "-=[]\\#;'`,./";
      punct_shift  = "_+{}|~:@~<>?";
      keypad       = "/*-+\n1234567890.";
      for (int i = 0; i < MAP_SIZE; i++) begin
         normal_chars[i]  = '0;
         shifted_chars[i] = '0;
      end
      for (int i = 0; i < 26; i++) begin
         normal_chars[4 + i]  = 7'(8'h61 + i);
         shifted_chars[4 + i] = 7'(8'h41 + i);
      end
      for (int i = 0; i < 10; i++) begin
         normal_chars[30 + i]  = 7'(digits_plain[i]);
         shifted_chars[30 + i] = 7'(digits_shift[i]);
      end
      for (int i = 0; i < 12; i++) begin
         normal_chars[45 + i]  = 7'(punct_plain[i]);
         shifted_chars[45 + i] = 7'(punct_shift[i]);
      end
      for (int i = 0; i < 16; i++) begin
         normal_chars[84 + i]  = 7'(keypad[i]);
         shifted_chars[84 + i] = 7'(keypad[i]);
      end
      normal_chars[40]   = 7'h0a;
      shifted_chars[40]  = 7'h0a;
      normal_chars[42]   = 7'h08;
      shifted_chars[42]  = 7'h08;
      normal_chars[43]   = 7'h09;
      shifted_chars[43]  = 7'h09;
      normal_chars[44]   = 7'h20;
      shifted_chars[44]  = 7'h20;
      normal_chars[100]  = 7'h5c;
      shifted_chars[100] = 7'h7c;
      normal_chars[103]  = 7'h3d;
      shifted_chars[103] = 7'h3d;
      for (int k = 0; k < hkra_pkg::KEY_SLOTS; k++) begin
         held_codes[k] = '0;
      end
   end

   // Character for the first newly pressed key; the report then becomes the held set.
   function automatic hkra_pkg::char_type predict_new_char(input key_report_type rep);
      hkra_pkg::char_type found;
      hkra_pkg::char_type ch;
      hkra_pkg::code_type code;
      logic               shifted;
      logic               held;
      found   = '0;
      shifted = (rep.mods & SHIFT_KEYS) != '0;
      for (int s = 0; s < hkra_pkg::KEY_SLOTS; s++) begin
         code = rep.codes[s];
         if (code == '0) break;
         if (code >= MAP_SIZE) continue;
         held = 1'b0;
         for (int k = 0; k < hkra_pkg::KEY_SLOTS; k++) begin
            if (held_codes[k] == code) held = 1'b1;
         end
         if (held) continue;
         ch = shifted ? shifted_chars[code] : normal_chars[code];
         if (ch != '0) begin
            found = ch;
            break;
         end
      end
      for (int k = 0; k < hkra_pkg::KEY_SLOTS; k++) begin
         held_codes[k] = rep.codes[k];
      end
      return found;
   endfunction

   // Models a typist: keys go down and come up one at a time, with an
   // occasional phantom-key (rollover) report.
   function automatic key_report_type next_typed_report();
      key_report_type     rep;
      int                 pick;
      int                 kind;
      hkra_pkg::code_type code;
      pick = $urandom_range(99);
      if (pick < 45 && pressed_keys.size() < hkra_pkg::KEY_SLOTS) begin
         kind = $urandom_range(99);
         if (kind < 85) code = hkra_pkg::code_type'($urandom_range(MAP_SIZE - 1, 4));
         else if (kind < 95) code = hkra_pkg::code_type'($urandom_range(255, MAP_SIZE));
         else code = hkra_pkg::code_type'($urandom_range(3, 1));
         pressed_keys.insert($urandom_range(pressed_keys.size()), code);
      end else if (pick < 85 && pressed_keys.size() != 0) begin
         pressed_keys.delete($urandom_range(pressed_keys.size() - 1));
      end
      rep.codes = '0;
      if (pick >= 85 && pick < 90) begin
         for (int s = 0; s < hkra_pkg::KEY_SLOTS; s++) rep.codes[s] = ROLLOVER_CODE;
      end else begin
         for (int s = 0; s < pressed_keys.size(); s++) rep.codes[s] = pressed_keys[s];
      end
      rep.mods = hkra_pkg::code_type'($urandom_range(255));
      if ($urandom_range(1)) rep.mods = rep.mods & ~SHIFT_KEYS;
      return rep;
   endfunction

   // Mostly typing, some fully random reports, some with a hole in the slots.
   function automatic key_report_type next_mixed_report();
      key_report_type rep;
      int             pick;
      pick = $urandom_range(99);
      rep  = next_typed_report();
      if (pick >= 93) begin
         rep.codes[$urandom_range(hkra_pkg::KEY_SLOTS - 1)] = '0;
      end else if (pick >= 78) begin
         rep.codes = hkra_pkg::codes_type'({$urandom, $urandom});
         rep.mods  = hkra_pkg::code_type'($urandom_range(255));
      end
      return rep;
   endfunction

   task automatic send_report(input key_report_type rep);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.slot0_code    <= rep.codes[0];
      req_bus.slot1_code    <= rep.codes[1];
      req_bus.slot2_code    <= rep.codes[2];
      req_bus.slot3_code    <= rep.codes[3];
      req_bus.slot4_code    <= rep.codes[4];
      req_bus.slot5_code    <= rep.codes[5];
      req_bus.modifier_bits <= rep.mods;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      expected_chars.push_back(predict_new_char(rep));
   endtask

   task automatic send_keys(input hkra_pkg::code_type k0, k1, k2, k3, k4, k5,
                            input hkra_pkg::code_type mods);
      key_report_type rep;
      rep.codes = {k5, k4, k3, k2, k1, k0};
      rep.mods  = mods;
      send_report(rep);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic send_mixed_reports(input int count);
      repeat (count) send_report(next_mixed_report());
      drain_results();
   endtask

   task automatic test_directed_cases();
      send_keys(0, 0, 0, 0, 0, 0, 8'h00);
      send_keys(4, 0, 0, 0, 0, 0, 8'h00);
      send_keys(4, 0, 0, 0, 0, 0, 8'h00);
      send_keys(4, 5, 0, 0, 0, 0, 8'h00);
      send_keys(0, 0, 0, 0, 0, 0, 8'h00);
      send_keys(4, 0, 0, 0, 0, 0, 8'h02);
      send_keys(29, 0, 0, 0, 0, 0, 8'h20);
      send_keys(30, 0, 0, 0, 0, 0, 8'hdd);
      send_keys(255, 5, 0, 0, 0, 0, 8'h00);
      send_keys(104, 103, 0, 0, 0, 0, 8'h22);
      send_keys(1, 2, 3, 57, 6, 0, 8'h00);
      send_keys(0, 7, 8, 9, 10, 11, 8'h00);
      send_keys(7, 0, 0, 0, 0, 0, 8'h00);
      send_keys(255, 255, 255, 255, 255, 255, 8'hff);
      send_keys(200, 104, 1, 2, 3, 103, 8'h00);
      send_keys(101, 102, 41, 57, 58, 100, 8'h02);
      send_keys(0, 0, 0, 0, 0, 0, 8'h00);
      send_keys(100, 0, 0, 0, 0, 0, 8'h00);
      send_keys(56, 53, 45, 0, 0, 0, 8'h20);
      send_keys(44, 0, 0, 0, 0, 0, 8'h00);
      send_keys(40, 44, 0, 0, 0, 0, 8'h00);
      send_keys(128, 64, 32, 16, 0, 0, 8'h80);
      drain_results();
   endtask

   task automatic test_streaming();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_mixed_reports(450);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 59;
      stall_pct     = 0;
      send_mixed_reports(450);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      stall_pct     = 59;
      send_mixed_reports(450);
   endtask

   task automatic test_both_gaps();
      send_idle_pct = 20;
      stall_pct     = 20;
      send_mixed_reports(450);
   endtask

   // The receiver holds off long enough for the decoder to fill and stall
   // its input; the sender then waits for every result before going on.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      @(posedge clock);
      hold_off_cycles = 80;
      send_mixed_reports(40);
      stall_pct = 30;
      send_mixed_reports(40);
      stall_pct = 0;
   endtask

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_bus.ready   <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_chars
      hkra_pkg::char_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_chars.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("tb_top: unexpected transaction, key_char %h", rsp_bus.key_char);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_bus.key_char !== want) begin
               failures++;
               if (failures <= REPORT_MAX)
                  $display("tb_top: key_char mismatch: expected %h, got %h",
                           want, rsp_bus.key_char);
            end
         end
      end
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.slot0_code    = '0;
      req_bus.slot1_code    = '0;
      req_bus.slot2_code    = '0;
      req_bus.slot3_code    = '0;
      req_bus.slot4_code    = '0;
      req_bus.slot5_code    = '0;
      req_bus.modifier_bits = '0;
      rsp_bus.ready         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_gaps();
      test_backpressure();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
